FILE: src/bsqb_pkg.sv
// Shared constants, codes and item types of the stack and queue bank.
`default_nettype none
package bsqb_pkg;

  localparam int NUM_STACKS = 10;
  localparam int NUM_QUEUES = 10;
  localparam int CAPACITY   = 10;
  localparam int WORD_WIDTH = 32;

  localparam int FILL_W  = $clog2(CAPACITY + 1);
  localparam int POS_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SUM_W   = FILL_W + 1;
  localparam int SIDX_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SADDR_W = (NUM_STACKS * CAPACITY > 1) ? $clog2(NUM_STACKS * CAPACITY) : 1;
  localparam int QADDR_W = (NUM_QUEUES * CAPACITY > 1) ? $clog2(NUM_QUEUES * CAPACITY) : 1;

  // action codes
  localparam logic [3:0] ACT_NEW_S   = 4'd0;
  localparam logic [3:0] ACT_PUSH    = 4'd1;
  localparam logic [3:0] ACT_POP     = 4'd2;
  localparam logic [3:0] ACT_S2S     = 4'd3;
  localparam logic [3:0] ACT_DEL_S   = 4'd4;
  localparam logic [3:0] ACT_PRINT_S = 4'd5;
  localparam logic [3:0] ACT_NEW_Q   = 4'd6;
  localparam logic [3:0] ACT_ENQ     = 4'd7;
  localparam logic [3:0] ACT_DEQ     = 4'd8;
  localparam logic [3:0] ACT_DEL_Q   = 4'd9;
  localparam logic [3:0] ACT_PRINT_Q = 4'd10;
  localparam logic [3:0] ACT_S2Q     = 4'd11;
  localparam logic [3:0] ACT_Q2Q     = 4'd12;
  localparam logic [3:0] ACT_Q2S     = 4'd13;

  // status codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_SFULL    = 4'd1;
  localparam logic [3:0] ST_SEMPTY   = 4'd2;
  localparam logic [3:0] ST_REFUSED  = 4'd3;
  localparam logic [3:0] ST_QFULL    = 4'd4;
  localparam logic [3:0] ST_QEMPTY   = 4'd5;
  localparam logic [3:0] ST_NOTALLOC = 4'd6;
  localparam logic [3:0] ST_ELEM     = 4'd7;
  localparam logic [3:0] ST_PEMPTY   = 4'd8;

  typedef struct packed {
    logic [3:0]         action;
    logic [3:0]         first_index;
    logic [3:0]         second_index;
    logic signed [31:0] push_value;
  } bsqb_req_t;

  typedef struct packed {
    logic [3:0]         status;
    logic signed [31:0] element;
    logic               last;
  } bsqb_rsp_t;

  typedef struct packed {
    logic [POS_W-1:0]  head;
    logic [FILL_W-1:0] fill;
  } bsqb_qmeta_t;

endpackage
`default_nettype wire

FILE: src/bsqb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bsqb_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: src/bounded_stack_queue_bank.sv
// Top level of the bounded stack and queue bank.
//
// An item is taken only while the controller is idle. The per-structure fill
// and head words live in small RAMs read on acceptance, and the decision is
// made in the next cycle from their registered read data. A move reads the
// source word out of the word RAM in the decide state and writes it to the
// destination in the move state. A print walks the word RAM one entry per
// read, through a read state and a load state for each element. A stalled
// result sits in the output register; the controller goes on with the next
// item and waits only when its next result is ready before the stalled one
// is taken. Live flags are flip-flops cleared at reset, so no clearing pass
// is needed.
`default_nettype none
module bounded_stack_queue_bank (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire bsqb_pkg::bsqb_req_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output bsqb_pkg::bsqb_rsp_t      rsp
);
  import bsqb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_MOVE, S_RESP, S_PRINT_RD, S_PRINT_LOAD
  } state_t;

  function automatic logic [POS_W-1:0] wrap_add(input logic [POS_W-1:0] h,
                                                 input logic [FILL_W-1:0] f);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(f);
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return POS_W'(s);
  endfunction

  function automatic logic [SADDR_W-1:0] saddr(input logic [SIDX_W-1:0] idx,
                                                input logic [POS_W-1:0] pos);
    return SADDR_W'(int'(idx) * CAPACITY + int'(pos));
  endfunction

  function automatic logic [QADDR_W-1:0] qaddr(input logic [QIDX_W-1:0] idx,
                                                input logic [POS_W-1:0] pos);
    return QADDR_W'(int'(idx) * CAPACITY + int'(pos));
  endfunction

  function automatic logic [WORD_WIDTH-1:0] to_word(input logic signed [31:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[WORD_WIDTH-1:0];
  endfunction

  function automatic logic signed [31:0] to_elem(input logic [WORD_WIDTH-1:0] w);
    logic signed [63:0] x;
    x = 64'(signed'(w));
    return x[31:0];
  endfunction

  state_t            state;
  bsqb_req_t         cur;
  logic [NUM_STACKS-1:0] s_alive;
  logic [NUM_QUEUES-1:0] q_alive;
  logic [3:0]        st_pend;

  logic              mv_from_stack;
  logic              mv_to_stack;
  logic [FILL_W-1:0] dfill;
  logic [POS_W-1:0]  dhead;

  logic              pr_stack;
  logic [FILL_W-1:0] pr_cnt;
  logic [POS_W-1:0]  pr_pos;

  // RAM ports
  logic                  sm_re, qm_re;
  logic [SIDX_W-1:0]     sm_ra, sm_rb;
  logic [QIDX_W-1:0]     qm_ra, qm_rb;
  logic                  sm_we, qm_we;
  logic [SIDX_W-1:0]     sm_waddr;
  logic [QIDX_W-1:0]     qm_waddr;
  logic [FILL_W-1:0]     sm_wdata;
  bsqb_qmeta_t           qm_wdata;
  logic [FILL_W-1:0]     sfa, sfb;
  bsqb_qmeta_t           qma, qmb;

  logic                  sw_we, sw_re, qw_we, qw_re;
  logic [SADDR_W-1:0]    sw_waddr, sw_raddr;
  logic [QADDR_W-1:0]    qw_waddr, qw_raddr;
  logic [WORD_WIDTH-1:0] sw_wdata, qw_wdata, sw_q, qw_q, mv_word;

  // decision
  logic                  req_take, out_free, rsp_load;
  logic [SIDX_W-1:0]     sa_idx, sb_idx;
  logic [QIDX_W-1:0]     qa_idx, qb_idx;
  logic                  sa_ok, sb_ok, qa_ok, qb_ok;
  logic                  src_stack, dst_stack, ok_src, ok_dst, same_struct;
  logic                  empty_src, full_dst;
  logic [3:0]            dec_status;
  logic                  dec_move, dec_print;
  logic                  s_set, s_clr, q_set, q_clr;
  logic [FILL_W-1:0]     mv_dfill;
  logic [POS_W-1:0]      mv_dhead;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  // a new result goes into the output register this cycle
  assign rsp_load  = out_free && (((state == S_DECIDE) && !dec_move && !dec_print) ||
                                  (state == S_MOVE) || (state == S_RESP) ||
                                  (state == S_PRINT_LOAD));

  assign sa_idx = SIDX_W'(cur.first_index);
  assign sb_idx = SIDX_W'(cur.second_index);
  assign qa_idx = QIDX_W'(cur.first_index);
  assign qb_idx = QIDX_W'(cur.second_index);
  assign sa_ok  = (int'(cur.first_index) < NUM_STACKS) ? s_alive[sa_idx] : 1'b0;
  assign sb_ok  = (int'(cur.second_index) < NUM_STACKS) ? s_alive[sb_idx] : 1'b0;
  assign qa_ok  = (int'(cur.first_index) < NUM_QUEUES) ? q_alive[qa_idx] : 1'b0;
  assign qb_ok  = (int'(cur.second_index) < NUM_QUEUES) ? q_alive[qb_idx] : 1'b0;

  assign src_stack   = (cur.action == ACT_S2S) || (cur.action == ACT_S2Q);
  assign dst_stack   = (cur.action == ACT_S2S) || (cur.action == ACT_Q2S);
  assign ok_src      = src_stack ? sa_ok : qa_ok;
  assign ok_dst      = dst_stack ? sb_ok : qb_ok;
  assign empty_src   = src_stack ? (sfa == '0) : (qma.fill == '0);
  assign full_dst    = dst_stack ? (int'(sfb) >= CAPACITY) : (int'(qmb.fill) >= CAPACITY);
  // a move onto itself sees the source already popped
  assign same_struct = (cur.first_index == cur.second_index) && (src_stack == dst_stack);
  assign mv_word     = mv_from_stack ? sw_q : qw_q;

  always_comb begin
    mv_dfill = dst_stack ? sfb : qmb.fill;
    mv_dhead = qmb.head;
    if (same_struct) begin
      mv_dfill = dst_stack ? FILL_W'(sfa - 1'b1) : FILL_W'(qma.fill - 1'b1);
      mv_dhead = wrap_add(qma.head, FILL_W'(1));
    end
  end

  always_comb begin
    sm_re    = req_take;
    qm_re    = req_take;
    sm_ra    = SIDX_W'(req.first_index);
    sm_rb    = SIDX_W'(req.second_index);
    qm_ra    = QIDX_W'(req.first_index);
    qm_rb    = QIDX_W'(req.second_index);
    sm_we    = 1'b0;
    sm_waddr = sa_idx;
    sm_wdata = '0;
    qm_we    = 1'b0;
    qm_waddr = qa_idx;
    qm_wdata = '0;
    sw_we    = 1'b0;
    sw_waddr = '0;
    sw_wdata = to_word(cur.push_value);
    sw_re    = 1'b0;
    sw_raddr = '0;
    qw_we    = 1'b0;
    qw_waddr = '0;
    qw_wdata = to_word(cur.push_value);
    qw_re    = 1'b0;
    qw_raddr = '0;
    dec_status = ST_OK;
    dec_move   = 1'b0;
    dec_print  = 1'b0;
    s_set = 1'b0;
    s_clr = 1'b0;
    q_set = 1'b0;
    q_clr = 1'b0;

    case (state)
      S_DECIDE: begin
        case (cur.action)
          ACT_NEW_S, ACT_DEL_S: begin
            if (int'(cur.first_index) >= NUM_STACKS) begin
              dec_status = ST_NOTALLOC;
            end else begin
              s_set = (cur.action == ACT_NEW_S);
              s_clr = (cur.action == ACT_DEL_S);
              sm_we = 1'b1;
            end
          end
          ACT_NEW_Q, ACT_DEL_Q: begin
            if (int'(cur.first_index) >= NUM_QUEUES) begin
              dec_status = ST_NOTALLOC;
            end else begin
              q_set = (cur.action == ACT_NEW_Q);
              q_clr = (cur.action == ACT_DEL_Q);
              qm_we = 1'b1;
            end
          end
          ACT_PUSH: begin
            if (!sa_ok) begin
              dec_status = ST_NOTALLOC;
            end else if (int'(sfa) >= CAPACITY) begin
              dec_status = ST_SFULL;
            end else begin
              sw_we    = 1'b1;
              sw_waddr = saddr(sa_idx, POS_W'(sfa));
              sm_we    = 1'b1;
              sm_wdata = FILL_W'(sfa + 1'b1);
            end
          end
          ACT_POP: begin
            if (!sa_ok) begin
              dec_status = ST_NOTALLOC;
            end else if (sfa == '0) begin
              dec_status = ST_SEMPTY;
            end else begin
              sm_we    = 1'b1;
              sm_wdata = FILL_W'(sfa - 1'b1);
            end
          end
          ACT_ENQ: begin
            if (!qa_ok) begin
              dec_status = ST_NOTALLOC;
            end else if (int'(qma.fill) >= CAPACITY) begin
              dec_status = ST_QFULL;
            end else begin
              qw_we         = 1'b1;
              qw_waddr      = qaddr(qa_idx, wrap_add(qma.head, qma.fill));
              qm_we         = 1'b1;
              qm_wdata.head = qma.head;
              qm_wdata.fill = FILL_W'(qma.fill + 1'b1);
            end
          end
          ACT_DEQ: begin
            if (!qa_ok) begin
              dec_status = ST_NOTALLOC;
            end else if (qma.fill == '0) begin
              dec_status = ST_QEMPTY;
            end else begin
              qm_we         = 1'b1;
              qm_wdata.head = wrap_add(qma.head, FILL_W'(1));
              qm_wdata.fill = FILL_W'(qma.fill - 1'b1);
            end
          end
          ACT_PRINT_S: begin
            if (!sa_ok) begin
              dec_status = ST_NOTALLOC;
            end else if (sfa == '0) begin
              dec_status = ST_PEMPTY;
            end else begin
              dec_print = 1'b1;
            end
          end
          ACT_PRINT_Q: begin
            if (!qa_ok) begin
              dec_status = ST_NOTALLOC;
            end else if (qma.fill == '0) begin
              dec_status = ST_PEMPTY;
            end else begin
              dec_print = 1'b1;
            end
          end
          ACT_S2S, ACT_S2Q, ACT_Q2Q, ACT_Q2S: begin
            if (!ok_src || !ok_dst) begin
              dec_status = ST_NOTALLOC;
            end else if (empty_src || full_dst) begin
              dec_status = ST_REFUSED;
            end else begin
              dec_move = 1'b1;
              // pop the source now, push the word next cycle
              if (src_stack) begin
                sw_re    = 1'b1;
                sw_raddr = saddr(sa_idx, POS_W'(sfa - 1'b1));
                sm_we    = 1'b1;
                sm_wdata = FILL_W'(sfa - 1'b1);
              end else begin
                qw_re         = 1'b1;
                qw_raddr      = qaddr(qa_idx, qma.head);
                qm_we         = 1'b1;
                qm_wdata.head = wrap_add(qma.head, FILL_W'(1));
                qm_wdata.fill = FILL_W'(qma.fill - 1'b1);
              end
            end
          end
          default: begin
            dec_status = ST_OK;
          end
        endcase
      end
      S_MOVE: begin
        if (mv_to_stack) begin
          sw_we    = 1'b1;
          sw_waddr = saddr(sb_idx, POS_W'(dfill));
          sw_wdata = mv_word;
          sm_we    = 1'b1;
          sm_waddr = sb_idx;
          sm_wdata = FILL_W'(dfill + 1'b1);
        end else begin
          qw_we         = 1'b1;
          qw_waddr      = qaddr(qb_idx, wrap_add(dhead, dfill));
          qw_wdata      = mv_word;
          qm_we         = 1'b1;
          qm_waddr      = qb_idx;
          qm_wdata.head = dhead;
          qm_wdata.fill = FILL_W'(dfill + 1'b1);
        end
      end
      S_PRINT_RD: begin
        if (pr_stack) begin
          sw_re    = 1'b1;
          sw_raddr = saddr(sa_idx, pr_pos);
        end else begin
          qw_re    = 1'b1;
          qw_raddr = qaddr(qa_idx, pr_pos);
        end
      end
      default: begin
        sm_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      s_alive   <= '0;
      q_alive   <= '0;
    end else begin
      rsp_valid <= rsp_load || (rsp_valid && rsp_stall);
      if (s_set) s_alive[sa_idx] <= 1'b1;
      if (s_clr) s_alive[sa_idx] <= 1'b0;
      if (q_set) q_alive[qa_idx] <= 1'b1;
      if (q_clr) q_alive[qa_idx] <= 1'b0;

      case (state)
        S_IDLE: begin
          if (req_take) begin
            cur   <= req;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (dec_move) begin
            mv_from_stack <= src_stack;
            mv_to_stack   <= dst_stack;
            dfill         <= mv_dfill;
            dhead         <= mv_dhead;
            state         <= S_MOVE;
          end else if (dec_print) begin
            pr_stack <= (cur.action == ACT_PRINT_S);
            if (cur.action == ACT_PRINT_S) begin
              pr_cnt <= sfa;
              pr_pos <= '0;
            end else begin
              pr_cnt <= qma.fill;
              pr_pos <= wrap_add(qma.head, FILL_W'(qma.fill - 1'b1));
            end
            state <= S_PRINT_RD;
          end else if (out_free) begin
            rsp.status  <= dec_status;
            rsp.element <= '0;
            rsp.last    <= 1'b1;
            state       <= S_IDLE;
          end else begin
            st_pend <= dec_status;
            state   <= S_RESP;
          end
        end
        S_MOVE: begin
          if (out_free) begin
            rsp.status  <= ST_OK;
            rsp.element <= '0;
            rsp.last    <= 1'b1;
            state       <= S_IDLE;
          end else begin
            st_pend <= ST_OK;
            state   <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            rsp.status  <= st_pend;
            rsp.element <= '0;
            rsp.last    <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_PRINT_RD: begin
          state <= S_PRINT_LOAD;
        end
        S_PRINT_LOAD: begin
          if (out_free) begin
            rsp.status  <= ST_ELEM;
            rsp.element <= to_elem(pr_stack ? sw_q : qw_q);
            rsp.last    <= (pr_cnt == FILL_W'(1));
            if (pr_cnt == FILL_W'(1)) begin
              state <= S_IDLE;
            end else begin
              pr_cnt <= FILL_W'(pr_cnt - 1'b1);
              // stacks bottom up, queues back to front
              if (pr_stack) begin
                pr_pos <= POS_W'(pr_pos + 1'b1);
              end else if (pr_pos == '0) begin
                pr_pos <= POS_W'(CAPACITY - 1);
              end else begin
                pr_pos <= POS_W'(pr_pos - 1'b1);
              end
              state <= S_PRINT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // metadata RAMs: one copy per read port, written together
  bsqb_ram #(.DEPTH(NUM_STACKS), .WIDTH(FILL_W)) u_smeta_a (
    .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .re(sm_re), .raddr(sm_ra), .rdata(sfa)
  );
  bsqb_ram #(.DEPTH(NUM_STACKS), .WIDTH(FILL_W)) u_smeta_b (
    .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .re(sm_re), .raddr(sm_rb), .rdata(sfb)
  );
  bsqb_ram #(.DEPTH(NUM_QUEUES), .WIDTH($bits(bsqb_qmeta_t))) u_qmeta_a (
    .clk(clk), .we(qm_we), .waddr(qm_waddr), .wdata(qm_wdata),
    .re(qm_re), .raddr(qm_ra), .rdata(qma)
  );
  bsqb_ram #(.DEPTH(NUM_QUEUES), .WIDTH($bits(bsqb_qmeta_t))) u_qmeta_b (
    .clk(clk), .we(qm_we), .waddr(qm_waddr), .wdata(qm_wdata),
    .re(qm_re), .raddr(qm_rb), .rdata(qmb)
  );

  bsqb_ram #(.DEPTH(NUM_STACKS * CAPACITY), .WIDTH(WORD_WIDTH)) u_swords (
    .clk(clk), .we(sw_we), .waddr(sw_waddr), .wdata(sw_wdata),
    .re(sw_re), .raddr(sw_raddr), .rdata(sw_q)
  );
  bsqb_ram #(.DEPTH(NUM_QUEUES * CAPACITY), .WIDTH(WORD_WIDTH)) u_qwords (
    .clk(clk), .we(qw_we), .waddr(qw_waddr), .wdata(qw_wdata),
    .re(qw_re), .raddr(qw_raddr), .rdata(qw_q)
  );

  a_sfill_bound: assert property (@(posedge clk) disable iff (rst)
    sm_we |-> (int'(sm_wdata) <= CAPACITY))
    else $error("stack fill written beyond capacity");

  a_qmeta_bound: assert property (@(posedge clk) disable iff (rst)
    qm_we |-> ((int'(qm_wdata.fill) <= CAPACITY) && (int'(qm_wdata.head) < CAPACITY)))
    else $error("queue head or fill written out of range");

  a_elem_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ST_ELEM)) |-> (rsp.element == '0))
    else $error("non-element result carries a word");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    req_take |=> req_stall)
    else $error("controller not busy after taking an item");

  a_print_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRINT_RD) |-> (pr_cnt != '0))
    else $error("print walk with nothing left");

endmodule
`default_nettype wire
